[hdl/srfs_pkg.sv]
// Package: shared types and constants for the shortest-remaining-first selector.
`default_nettype none

package srfs_pkg;

  // Field widths fixed by the request and result formats
  localparam int TIME_W       = 16;
  localparam int SLOT_FIELD_W = 4;

  // Default configuration of the selector
  localparam int SLOT_COUNT_DEFAULT = 16;
  localparam int TIME_BITS_DEFAULT  = 16;

  // One process-table entry of a scan
  typedef struct packed {
    logic [TIME_W-1:0] arr_time;
    logic [TIME_W-1:0] rem_time;
    logic [TIME_W-1:0] current_time;
    logic              last_entry;
  } in_req_t;

  // One scheduling decision
  typedef struct packed {
    logic                    selected_valid;
    logic [SLOT_FIELD_W-1:0] selected_slot;
    logic                    preempt_event;
    logic [SLOT_FIELD_W-1:0] preempted_slot;
    logic                    resume_event;
  } out_res_t;

endpackage : srfs_pkg

`default_nettype wire

[hdl/shortest_remaining_first_select_top.sv]
// Top level of the shortest-remaining-first selector.
//
// Usage: for each scheduling decision, send the process-table entries as
// requests on the in channel (in_valid_i / in_ready_o / in_data_i), one per
// slot in slot order starting at slot zero, with last_entry set on the final
// one. Each entry carries arrival time, remaining time and the current time.
// For every last entry one decision comes out on the out channel
// (out_valid_o / out_ready_i / out_data_o): the selected slot, whether the
// previous runner was preempted with work left, and whether the new pick
// resumes after an earlier preemption. Other entries produce no output.
// A last entry is held in the input register, then one pass of compare logic
// writes its decision into the output register. Throughput: one entry per
// cycle, save a last entry held while the output register is busy; the
// compare-and-update against the running best is a single pass per entry.
// Reset clears the scan position, the running best, the runner record and all
// per-slot preempted flags. When the receiver stalls, the decision holds in
// the output register; ordinary entries keep flowing, and a further last
// entry waits in the input register until the output register frees.
`default_nettype none

module shortest_remaining_first_select_top
  import srfs_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
  parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire in_req_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_res_t     out_data_o
);

  logic     item_valid, item_ready;
  in_req_t  item;
  logic     res_valid, res_ready;
  out_res_t res;

  // Register incoming entries
  srfs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Compare, track runner and flags
  srfs_select #(
    .SLOT_COUNT (SLOT_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Register outgoing decisions
  srfs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule : shortest_remaining_first_select_top

`default_nettype wire

[hdl/srfs_in_reg.sv]
// Input register: holds one table-entry request ahead of the selection logic.
`default_nettype none

module srfs_in_reg
  import srfs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire in_req_t in_data_i,
  output logic         item_valid_o,
  input  wire logic    item_ready_i,
  output in_req_t      item_o
);

  logic    valid_q, valid_d;
  in_req_t data_q;

  // Accept when empty or when the held request moves on this cycle
  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept; hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule : srfs_in_reg

`default_nettype wire

[hdl/srfs_select.sv]
// Selection logic: running minimum over one scan, runner tracking, preempt flags.
`default_nettype none

module srfs_select
  import srfs_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
  parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    item_valid_i,
  output logic         item_ready_o,
  input  wire in_req_t item_i,
  output logic         res_valid_o,
  input  wire logic    res_ready_i,
  output out_res_t     res_o
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TW     = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

  // Scan and runner state
  logic [SLOT_W-1:0]     scan_q, scan_d;
  logic                  best_found_q, best_found_d;
  logic [SLOT_W-1:0]     best_slot_q, best_slot_d;
  logic [TW-1:0]         best_rem_q, best_rem_d;
  logic [TW-1:0]         best_arr_q, best_arr_d;
  logic                  runner_valid_q, runner_valid_d;
  logic [SLOT_W-1:0]     runner_slot_q, runner_slot_d;
  logic [TW-1:0]         runner_rem_q, runner_rem_d;
  logic [SLOT_COUNT-1:0] flags_q, flags_d;

  logic [TW-1:0] arr, rem, now;
  logic          last, fire, eligible, take, sw, preempt, resume;
  logic [TW-1:0] run_rem_now;
  logic          nb_found;
  logic [SLOT_W-1:0] nb_slot;
  logic [TW-1:0]     nb_rem, nb_arr;
  logic [SLOT_W+SLOT_FIELD_W-1:0] sel_ext, pre_ext;

  // Take times in their low bits
  assign arr  = item_i.arr_time[TW-1:0];
  assign rem  = item_i.rem_time[TW-1:0];
  assign now  = item_i.current_time[TW-1:0];
  assign last = item_i.last_entry;

  // Stall only a last entry while the result slot is busy
  assign item_ready_o = !last || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign res_valid_o  = item_valid_i && last;

  // Compare this entry against the running best
  always_comb begin
    run_rem_now = (runner_valid_q && (scan_q == runner_slot_q)) ? rem : runner_rem_q;
    eligible    = (rem != '0) && (arr <= now);
    take        = eligible && (!best_found_q || (rem < best_rem_q) ||
                               ((rem == best_rem_q) && (arr < best_arr_q)));
    nb_found    = best_found_q || take;
    nb_slot     = take ? scan_q : best_slot_q;
    nb_rem      = take ? rem : best_rem_q;
    nb_arr      = take ? arr : best_arr_q;
    sw          = runner_valid_q && nb_found && (runner_slot_q != nb_slot);
    preempt     = sw && (run_rem_now != '0);
    resume      = sw && flags_q[nb_slot];
  end

  // Build the decision
  always_comb begin
    sel_ext = {{SLOT_FIELD_W{1'b0}}, nb_slot};
    pre_ext = {{SLOT_FIELD_W{1'b0}}, runner_slot_q};
    res_o.selected_valid = nb_found;
    res_o.selected_slot  = nb_found ? sel_ext[SLOT_FIELD_W-1:0] : '0;
    res_o.preempt_event  = preempt;
    res_o.preempted_slot = preempt ? pre_ext[SLOT_FIELD_W-1:0] : '0;
    res_o.resume_event   = resume;
  end

  // Advance the scan, or close it on the last entry
  always_comb begin
    scan_d         = scan_q;
    best_found_d   = best_found_q;
    best_slot_d    = best_slot_q;
    best_rem_d     = best_rem_q;
    best_arr_d     = best_arr_q;
    runner_valid_d = runner_valid_q;
    runner_slot_d  = runner_slot_q;
    runner_rem_d   = runner_rem_q;
    flags_d        = flags_q;
    if (fire) begin
      if (!last) begin
        scan_d       = (scan_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : scan_q + 1'b1;
        best_found_d = nb_found;
        best_slot_d  = nb_slot;
        best_rem_d   = nb_rem;
        best_arr_d   = nb_arr;
        runner_rem_d = run_rem_now;
      end else begin
        if (preempt) begin
          flags_d[runner_slot_q] = 1'b1;
        end
        if (resume) begin
          flags_d[nb_slot] = 1'b0;
        end
        runner_valid_d = nb_found;
        runner_slot_d  = nb_found ? nb_slot : '0;
        runner_rem_d   = '0;
        scan_d         = '0;
        best_found_d   = 1'b0;
        best_slot_d    = '0;
        best_rem_d     = '0;
        best_arr_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q         <= '0;
      best_found_q   <= 1'b0;
      best_slot_q    <= '0;
      best_rem_q     <= '0;
      best_arr_q     <= '0;
      runner_valid_q <= 1'b0;
      runner_slot_q  <= '0;
      runner_rem_q   <= '0;
      flags_q        <= '0;
    end else begin
      scan_q         <= scan_d;
      best_found_q   <= best_found_d;
      best_slot_q    <= best_slot_d;
      best_rem_q     <= best_rem_d;
      best_arr_q     <= best_arr_d;
      runner_valid_q <= runner_valid_d;
      runner_slot_q  <= runner_slot_d;
      runner_rem_q   <= runner_rem_d;
      flags_q        <= flags_d;
    end
  end

  // A resumed slot drops its preempted flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && resume) |=> !flags_q[$past(nb_slot)])
    else $error("resumed slot still carries a preempted flag");

  // A preemption marks the old runner for later resumption
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && preempt) |=> flags_q[$past(runner_slot_q)])
    else $error("preempted runner not flagged");

  // A closed scan restarts from slot zero with no candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last) |=> ((scan_q == '0) && !best_found_q))
    else $error("scan state not cleared after decision");

  // Events only accompany a valid selection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.preempt_event || res_o.resume_event)) |-> res_o.selected_valid)
    else $error("event without a selected slot");

endmodule : srfs_select

`default_nettype wire

[hdl/srfs_out_reg.sv]
// Output register: holds one decision until the receiver takes it.
`default_nettype none

module srfs_out_reg
  import srfs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     res_valid_i,
  output logic          res_ready_o,
  input  wire out_res_t res_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_res_t      out_data_o
);

  logic     valid_q, valid_d;
  out_res_t data_q;

  // Free when empty or drained this cycle
  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new decision; hold while stalled
  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule : srfs_out_reg

`default_nettype wire
